// ----- rtl/core/glpc_pkg.sv -----
// ----------------------------------------------------------------------------
// glpc_pkg
// Shared types and constants for the grid local peak counter.
// ----------------------------------------------------------------------------
`default_nettype none

package glpc_pkg;

  localparam int VALUE_W   = 64;
  localparam int ROW_W     = 16;
  localparam int COUNT_W   = 11;
  localparam int TOTAL_W   = 26;
  localparam int ACC_W     = 27;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int COLS_W    = 11;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 2'd0,
    CFG_GRID_ROWS    = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [COUNT_W-1:0] row_hotspots;
    logic [TOTAL_W-1:0] peak_total;
    logic               final_row;
  } result_t;

  typedef struct packed {
    logic [VALUE_W-1:0] up_far;
    logic [VALUE_W-1:0] left;
    logic [VALUE_W-1:0] center;
    logic [VALUE_W-1:0] right;
    logic [VALUE_W-1:0] prev1;
    logic [VALUE_W-1:0] prev2;
    logic               has_above;
    logic               has_up_far;
    logic               has_left;
    logic               has_left2;
    logic               has_right;
    logic               is_final;
    logic               is_last_col;
  } window_t;

  typedef struct packed {
    logic pend_hit;
    logic tail_hit;
    logic self_hit;
  } hits_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/core/glpc_line_store.sv -----
// ----------------------------------------------------------------------------
// glpc_line_store
// Two-row line store: one write port, two registered read ports with
// write-through on an address match.
// ----------------------------------------------------------------------------
`default_nettype none

module glpc_line_store #(
  parameter int AW = 11
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [glpc_pkg::VALUE_W-1:0] wr_data,
  input  wire logic [AW-1:0]               rd_addr_a,
  input  wire logic [AW-1:0]               rd_addr_b,
  output logic      [glpc_pkg::VALUE_W-1:0] rd_data_a,
  output logic      [glpc_pkg::VALUE_W-1:0] rd_data_b
);

  import glpc_pkg::*;

  logic [VALUE_W-1:0] mem [2**AW];
  logic [VALUE_W-1:0] mem_a;
  logic [VALUE_W-1:0] mem_b;
  logic [VALUE_W-1:0] wr_hold;
  logic               byp_a;
  logic               byp_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_a   <= mem[rd_addr_a];
    mem_b   <= mem[rd_addr_b];
    wr_hold <= wr_data;
    byp_a   <= wr_en && (wr_addr == rd_addr_a);
    byp_b   <= wr_en && (wr_addr == rd_addr_b);
  end

  assign rd_data_a = byp_a ? wr_hold : mem_a;
  assign rd_data_b = byp_b ? wr_hold : mem_b;

endmodule

`default_nettype wire

// ----- rtl/core/glpc_peak_eval.sv -----
// ----------------------------------------------------------------------------
// glpc_peak_eval
// Strict four-neighbour peak tests for the cells decided by one arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module glpc_peak_eval (
  input  wire logic [glpc_pkg::VALUE_W-1:0] arrival,
  input  wire glpc_pkg::window_t           win,
  output glpc_pkg::hits_t                  hits
);

  import glpc_pkg::*;

  always_comb begin
    hits.pend_hit = win.has_above
                 && (!win.has_up_far || (win.center > win.up_far))
                 && (win.center > arrival)
                 && (!win.has_left  || (win.center > win.left))
                 && (!win.has_right || (win.center > win.right));
    hits.tail_hit = win.is_final && win.has_left
                 && (!win.has_above || (win.prev1 > win.left))
                 && (!win.has_left2 || (win.prev1 > win.prev2))
                 && (win.prev1 > arrival);
    hits.self_hit = win.is_final && win.is_last_col
                 && (!win.has_above || (arrival > win.center))
                 && (!win.has_left  || (arrival > win.prev1));
  end

endmodule

`default_nettype wire

// ----- rtl/core/glpc_result_fifo.sv -----
// ----------------------------------------------------------------------------
// glpc_result_fifo
// Small result queue taking up to two results per cycle, one out per cycle when popped.
// ----------------------------------------------------------------------------
`default_nettype none

module glpc_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire glpc_pkg::push_t   push,
  input  wire glpc_pkg::result_t data0,
  input  wire glpc_pkg::result_t data1,
  output glpc_pkg::result_t      head,
  output logic                   head_valid,
  input  wire logic              pop,
  output logic                   room2
);

  import glpc_pkg::*;

  result_t                entry [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic [FIFO_CNT_W-1:0]  push_count;
  logic                   do_pop;

  assign push_count = FIFO_CNT_W'(push.first) + FIFO_CNT_W'(push.second);
  assign do_pop     = pop && head_valid;
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];
  assign room2      = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.first) begin
      entry[wr_ptr] <= data0;
    end
    if (push.second) begin
      entry[wr_ptr + FIFO_PTR_W'(1)] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count[FIFO_PTR_W-1:0];
      rd_ptr <= rd_ptr + FIFO_PTR_W'(do_pop);
      count  <= count + push_count - FIFO_CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/grid_local_peak_counter_unit.sv -----
// ----------------------------------------------------------------------------
// grid_local_peak_counter_unit
// Streaming counter of strict four-neighbour peaks in a raster grid.
// ----------------------------------------------------------------------------
// Takes one 64-bit cell per clock in raster order; every cell is decided in
// the cycle it (or the cell that completes its neighbourhood) is accepted,
// with the compares sitting between the window registers and a four-entry
// result queue. A row report is queued with the next row's last cell (its own
// if final); the last cell of a multi-row grid queues two reports. Input is
// held off while the queue has fewer than two free entries, so a stalled
// consumer stops the input after at most four queued reports. The line store
// holds two rows (2 x 2**ceil(log2(MAX_COLUMNS)) x 64 bits) and is read at
// two addresses each cycle; it needs no clearing after reset. A column or
// row write restarts the grid at row 0, column 0.
`default_nettype none

module grid_local_peak_counter_unit #(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [glpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [glpc_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [glpc_pkg::VALUE_W-1:0]   cell_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [glpc_pkg::ROW_W-1:0]     row_index,
  output logic      [glpc_pkg::COUNT_W-1:0]   row_hotspots,
  output logic      [glpc_pkg::TOTAL_W-1:0]   peak_total,
  output logic                                final_row
);

  import glpc_pkg::*;

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int CNT_W = CW + 1;
  localparam int AW    = CW + 1;

  function automatic logic [CNT_W-1:0] eff_cols(input logic [COLS_W-1:0] raw);
    logic [CNT_W-1:0] val;
    if (raw == '0) begin
      val = CNT_W'(1);
    end else if (32'(raw) > 32'(MAX_COLUMNS)) begin
      val = CNT_W'(MAX_COLUMNS);
    end else begin
      val = CNT_W'(raw);
    end
    return val;
  endfunction

  logic [COLS_W-1:0]  grid_columns;
  logic [COLS_W-1:0]  grid_columns_next;
  logic [ROW_W-1:0]   grid_rows;
  logic [ROW_W-1:0]   grid_rows_next;
  logic [CW-1:0]      col_pos;
  logic [CW-1:0]      col_pos_next;
  logic [ROW_W-1:0]   row_pos;
  logic [ROW_W-1:0]   row_pos_next;
  logic [COUNT_W-1:0] pending_count;
  logic [COUNT_W-1:0] pending_count_next;
  logic [COUNT_W-1:0] last_count;
  logic [COUNT_W-1:0] last_count_next;
  logic [ACC_W-1:0]   running_total;
  logic [ACC_W-1:0]   running_total_next;
  logic [VALUE_W-1:0] above_left;
  logic [VALUE_W-1:0] above_mid;
  logic [VALUE_W-1:0] prev1;
  logic [VALUE_W-1:0] prev2;

  logic               cfg_wr;
  logic               in_acc;
  logic [CNT_W-1:0]   cols_eff;
  logic [ROW_W-1:0]   rows_eff;
  logic [CNT_W-1:0]   col_plus;
  logic               last_col;
  logic               is_final;
  logic               has_above;

  logic [CNT_W-1:0]   ncols_eff;
  logic [CNT_W-1:0]   ncol_plus;
  logic [AW-1:0]      rd_addr_a;
  logic [AW-1:0]      rd_addr_b;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] rd_data_a;
  logic [VALUE_W-1:0] rd_data_b;

  window_t            win;
  hits_t              hits;
  logic [COUNT_W-1:0] pend_inc;
  logic [COUNT_W-1:0] last_inc;
  logic [ACC_W-1:0]   total1;
  logic [ACC_W-1:0]   total2;
  result_t            res0;
  result_t            res1;
  push_t              push;
  result_t            head;
  logic               room2;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = room2 && !cfg_wr;
  assign in_acc    = in_valid && in_ready;

  assign cols_eff  = eff_cols(grid_columns);
  assign rows_eff  = (grid_rows == '0) ? ROW_W'(1) : grid_rows;
  assign col_plus  = {1'b0, col_pos} + CNT_W'(1);
  assign last_col  = (col_plus >= cols_eff);
  assign is_final  = ({1'b0, row_pos} + 17'd1) >= {1'b0, rows_eff};
  assign has_above = (row_pos != '0);

  always_comb begin
    win.up_far      = rd_data_a;
    win.left        = above_left;
    win.center      = above_mid;
    win.right       = rd_data_b;
    win.prev1       = prev1;
    win.prev2       = prev2;
    win.has_above   = has_above;
    win.has_up_far  = (row_pos > ROW_W'(1));
    win.has_left    = (col_pos != '0);
    win.has_left2   = (col_pos > CW'(1));
    win.has_right   = !last_col;
    win.is_final    = is_final;
    win.is_last_col = last_col;
  end

  glpc_peak_eval u_eval (
    .arrival (cell_value),
    .win     (win),
    .hits    (hits)
  );

  assign pend_inc = pending_count + COUNT_W'(hits.pend_hit);
  assign last_inc = last_count + COUNT_W'(hits.tail_hit) + COUNT_W'(hits.self_hit);
  assign total1   = running_total + (has_above ? ACC_W'(pend_inc) : '0);
  assign total2   = total1 + ACC_W'(last_inc);

  always_comb begin
    res0.row_index    = row_pos - ROW_W'(1);
    res0.row_hotspots = pend_inc;
    res0.peak_total   = total1[TOTAL_W-1:0];
    res0.final_row    = 1'b0;
    res1.row_index    = row_pos;
    res1.row_hotspots = last_inc;
    res1.peak_total   = total2[TOTAL_W-1:0];
    res1.final_row    = 1'b1;
    push.first  = in_acc && last_col && (has_above || is_final);
    push.second = in_acc && last_col && has_above && is_final;
  end

  always_comb begin
    grid_columns_next  = grid_columns;
    grid_rows_next     = grid_rows;
    col_pos_next       = col_pos;
    row_pos_next       = row_pos;
    pending_count_next = pending_count;
    last_count_next    = last_count;
    running_total_next = running_total;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_GRID_COLUMNS: begin
          grid_columns_next  = cfg_data[COLS_W-1:0];
          col_pos_next       = '0;
          row_pos_next       = '0;
          pending_count_next = '0;
          last_count_next    = '0;
          running_total_next = '0;
        end
        CFG_GRID_ROWS: begin
          grid_rows_next     = cfg_data[ROW_W-1:0];
          col_pos_next       = '0;
          row_pos_next       = '0;
          pending_count_next = '0;
          last_count_next    = '0;
          running_total_next = '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (last_col) begin
        pending_count_next = '0;
        col_pos_next       = '0;
        if (is_final) begin
          row_pos_next       = '0;
          last_count_next    = '0;
          running_total_next = '0;
        end else begin
          row_pos_next       = row_pos + ROW_W'(1);
          running_total_next = total1;
          last_count_next    = last_inc;
        end
      end else begin
        col_pos_next       = col_plus[CW-1:0];
        pending_count_next = pend_inc;
        last_count_next    = last_inc;
      end
    end
  end

  assign ncols_eff = eff_cols(grid_columns_next);
  assign ncol_plus = {1'b0, col_pos_next} + CNT_W'(1);
  assign rd_addr_a = {row_pos_next[0], col_pos_next};
  assign rd_addr_b = (ncol_plus >= ncols_eff) ? {row_pos_next[0], CW'(0)}
                                              : {~row_pos_next[0], ncol_plus[CW-1:0]};
  assign wr_addr   = {row_pos[0], col_pos};

  glpc_line_store #(
    .AW (AW)
  ) u_line_store (
    .clk       (clk),
    .wr_en     (in_acc),
    .wr_addr   (wr_addr),
    .wr_data   (cell_value),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns  <= COLS_W'(1024);
      grid_rows     <= ROW_W'(1024);
      col_pos       <= '0;
      row_pos       <= '0;
      pending_count <= '0;
      last_count    <= '0;
      running_total <= '0;
    end else begin
      grid_columns  <= grid_columns_next;
      grid_rows     <= grid_rows_next;
      col_pos       <= col_pos_next;
      row_pos       <= row_pos_next;
      pending_count <= pending_count_next;
      last_count    <= last_count_next;
      running_total <= running_total_next;
    end
  end

  // advance the row-above window and the current-row history; a one-column row feeds itself
  always_ff @(posedge clk) begin
    if (in_acc) begin
      above_left <= above_mid;
      above_mid  <= (last_col && (col_pos == '0)) ? cell_value : rd_data_b;
      prev2      <= prev1;
      prev1      <= cell_value;
    end
  end

  glpc_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data0      (has_above ? res0 : res1),
    .data1      (res1),
    .head       (head),
    .head_valid (out_valid),
    .pop        (out_ready),
    .room2      (room2)
  );

  assign row_index    = head.row_index;
  assign row_hotspots = head.row_hotspots;
  assign peak_total   = head.peak_total;
  assign final_row    = head.final_row;

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_pos} < cols_eff))
    else $error("column position beyond grid width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (row_pos < rows_eff))
    else $error("row position beyond grid height");

  a_grid_restart: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last_col && is_final) |=>
      (row_pos == '0) && (col_pos == '0) && (running_total == '0))
    else $error("grid did not restart after its final cell");

endmodule

`default_nettype wire

// ----- verif/grid_local_peak_counter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// grid_local_peak_counter_unit_tb
// Self-checking bench for the streaming four-neighbour peak counter.
// ----------------------------------------------------------------------------
// Cells go in through a valid/ready stream and row reports come out the same
// way. A scripted run covers reset, grid restarts, degenerate sizes, ties and
// extreme values. Random grids follow, most complete and some cut short by a
// register write. Every accepted cell runs through a cycle-free model of the
// peak count, and each row report is checked field by field. Idling shifts
// between sender and receiver. One long receiver hold-off backs up the
// result queue.
module grid_local_peak_counter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import glpc_pkg::*;

  localparam int MAX_COLS      = 1024;
  localparam int RANDOM_CELLS  = 960;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SCRIPT_LEN    = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [VALUE_W-1:0]   TOP_VALUE   = '1;

  localparam result_t NONE     = '0;
  localparam result_t ONE_PEAK = '{16'd0, 11'd1, 26'd1, 1'b1};
  localparam result_t NO_PEAK  = '{16'd0, 11'd0, 26'd0, 1'b1};

  typedef enum logic {STEP_CELL, STEP_WRITE} step_kind_t;
  typedef enum int {FILL_TIES, FILL_WIDE, FILL_EXTREME, FILL_NEAR} fill_style_t;
  typedef enum int {SEND_LIGHT_TAKE_HEAVY, SEND_HEAVY_TAKE_LIGHT, NO_IDLE} idle_plan_t;

  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] reg_data;
    logic [VALUE_W-1:0]   value;
    bit                   typed;
    result_t              want;
  } script_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VALUE_W-1:0] cell_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROW_W-1:0]   row_index;
  logic [COUNT_W-1:0] row_hotspots;
  logic [TOTAL_W-1:0] peak_total;
  logic               final_row;

  // peak-count model state
  logic [VALUE_W-1:0] cell_store [2*MAX_COLS];
  int unsigned grid_cols = 1024;
  int unsigned grid_rows = 1024;
  int unsigned col_pos, row_pos, upper_count, final_count, grid_total;
  result_t report_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit stall_request = 1'b0;
  bit stall_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned cells_sent = 0;
  int unsigned writes_done = 0;
  int unsigned reports_seen = 0;
  int unsigned mismatches = 0;
  result_t head;

  script_step_t script [SCRIPT_LEN];

  grid_local_peak_counter_unit #(
    .MAX_COLUMNS(MAX_COLS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cell_value(cell_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .row_index(row_index),
    .row_hotspots(row_hotspots),
    .peak_total(peak_total),
    .final_row(final_row)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned active_cols();
    if (grid_cols == 0) return 1;
    return (grid_cols > MAX_COLS) ? MAX_COLS : grid_cols;
  endfunction

  function automatic int unsigned active_rows();
    return (grid_rows == 0) ? 1 : grid_rows;
  endfunction

  function automatic int unsigned store_slot(int unsigned r, int unsigned c);
    return (r & 1) * MAX_COLS + c % MAX_COLS;
  endfunction

  function automatic void restart_grid();
    col_pos = 0;
    row_pos = 0;
    upper_count = 0;
    final_count = 0;
    grid_total = 0;
  endfunction

  // Decide the cells completed by one arriving value and, if keep is set, queue the row reports.
  function automatic void count_peaks(input logic [VALUE_W-1:0] v, input bit keep);
    int unsigned cols, r, c;
    bit last_row, hit;
    logic [VALUE_W-1:0] mid;
    result_t rep;
    cols = active_cols();
    r = row_pos;
    c = col_pos;
    last_row = (r + 1 >= active_rows());
    if (r >= 1) begin
      mid = cell_store[store_slot(r - 1, c)];
      hit = (r < 2 || mid > cell_store[store_slot(r - 2, c)]) && mid > v &&
            (c < 1 || mid > cell_store[store_slot(r - 1, c - 1)]) &&
            (c + 1 >= cols || mid > cell_store[store_slot(r - 1, c + 1)]);
      if (hit) upper_count = (upper_count + 1) & 32'h7FF;
    end
    if (last_row && c >= 1) begin
      mid = cell_store[store_slot(r, c - 1)];
      hit = (r < 1 || mid > cell_store[store_slot(r - 1, c - 1)]) &&
            (c < 2 || mid > cell_store[store_slot(r, c - 2)]) && mid > v;
      if (hit) final_count = (final_count + 1) & 32'h7FF;
    end
    cell_store[store_slot(r, c)] = v;
    if (last_row && c + 1 >= cols) begin
      hit = (r < 1 || v > cell_store[store_slot(r - 1, c)]) &&
            (c < 1 || v > cell_store[store_slot(r, c - 1)]);
      if (hit) final_count = (final_count + 1) & 32'h7FF;
    end
    if (c + 1 >= cols) begin
      if (r >= 1) begin
        grid_total = (grid_total + upper_count) & 32'h7FFFFFF;
        rep = '{16'(r - 1), 11'(upper_count), 26'(grid_total), 1'b0};
        if (keep) report_q.push_back(rep);
      end
      upper_count = 0;
      if (last_row) begin
        grid_total = (grid_total + final_count) & 32'h7FFFFFF;
        rep = '{16'(r), 11'(final_count), 26'(grid_total), 1'b1};
        if (keep) report_q.push_back(rep);
        restart_grid();
      end else begin
        col_pos = 0;
        row_pos = (r + 1) & 32'hFFFF;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(fill_style_t style,
                                                    logic [VALUE_W-1:0] base);
    case (style)
      FILL_TIES: return 64'($urandom_range(3));
      FILL_WIDE: return {$urandom, $urandom};
      FILL_EXTREME: begin
        case ($urandom_range(3))
          0: return '0;
          1: return 64'd1;
          2: return TOP_VALUE - 64'd1;
          default: return TOP_VALUE;
        endcase
      end
      default: return {base[VALUE_W-1:2], 2'($urandom_range(3))};
    endcase
  endfunction

  task automatic set_idling(idle_plan_t plan);
    case (plan)
      SEND_LIGHT_TAKE_HEAVY: begin
        send_idle_pct = 13;
        recv_idle_pct <= 81;
      end
      SEND_HEAVY_TAKE_LIGHT: begin
        send_idle_pct = 81;
        recv_idle_pct <= 13;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
    endcase
  endtask

  // drop the input, wait out every pending report and the pipeline behind it
  task automatic settle();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    if (idx == CFG_GRID_COLUMNS) begin
      grid_cols = data & 16'h7FF;
      restart_grid();
    end else if (idx == CFG_GRID_ROWS) begin
      grid_rows = data;
      restart_grid();
    end
    cfg_valid <= 1'b0;
    writes_done++;
  endtask

  task automatic push_cell(input logic [VALUE_W-1:0] v, input bit typed,
                           input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cell_value <= v;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    count_peaks(v, !typed);
    if (typed) report_q.push_back(want);
    cells_sent++;
  endtask

  always @(posedge clk) begin
    if (stall_request != stall_seen) begin
      stall_seen <= stall_request;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        $error("row report with none pending: row_index %0d", row_index);
        mismatches++;
      end else begin
        head = report_q.pop_front();
        if (row_index !== head.row_index) begin
          $error("row_index expected %0d got %0d", head.row_index, row_index);
          mismatches++;
        end
        if (row_hotspots !== head.row_hotspots) begin
          $error("row_hotspots expected %0d got %0d", head.row_hotspots, row_hotspots);
          mismatches++;
        end
        if (peak_total !== head.peak_total) begin
          $error("peak_total expected %0d got %0d", head.peak_total, peak_total);
          mismatches++;
        end
        if (final_row !== head.final_row) begin
          $error("final_row expected %0d got %0d", head.final_row, final_row);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $error("run exceeded %0d cycles, %0d reports pending", LIMIT_CYCLES,
             report_q.size());
      $display("grid_local_peak_counter_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned random_cells, new_cols, new_rows, per_grid, grids, sent, pick;
    fill_style_t style;
    logic [VALUE_W-1:0] base;

    foreach (cell_store[i]) cell_store[i] = '0;
    restart_grid();
    script = '{
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd5,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, TOP_VALUE, 1'b0, NONE},
      '{STEP_WRITE, CFG_GRID_COLUMNS, 16'h0000, 64'd0,     1'b0, NONE},
      '{STEP_WRITE, CFG_GRID_ROWS,    16'h0000, 64'd0,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd0,     1'b1, ONE_PEAK},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, TOP_VALUE, 1'b1, ONE_PEAK},
      '{STEP_WRITE, CFG_GRID_COLUMNS, 16'h0002, 64'd0,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd0,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, TOP_VALUE, 1'b1, ONE_PEAK},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd7,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd7,     1'b1, NO_PEAK},
      '{STEP_WRITE, CFG_SPARE_A,      16'hFFFF, 64'd0,     1'b0, NONE},
      '{STEP_WRITE, CFG_SPARE_B,      16'h0000, 64'd0,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, TOP_VALUE, 1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd0,     1'b1, ONE_PEAK},
      '{STEP_WRITE, CFG_GRID_COLUMNS, 16'hF803, 64'd0,     1'b0, NONE},
      '{STEP_WRITE, CFG_GRID_ROWS,    16'h0003, 64'd0,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd1,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd1,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd1,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd1,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd9,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd1,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd1,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd1,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd1,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd4,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd2,     1'b0, NONE},
      '{STEP_WRITE, CFG_GRID_ROWS,    16'hFFFF, 64'd0,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd3,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd3,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd3,     1'b0, NONE},
      '{STEP_CELL,  CFG_GRID_COLUMNS, 16'h0000, 64'd8,     1'b0, NONE}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_idling(SEND_LIGHT_TAKE_HEAVY);

    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE)
        write_reg(script[i].reg_index, script[i].reg_data);
      else
        push_cell(script[i].value, script[i].typed, script[i].want);
    end

    // hold the receiver off while a one-column grid keeps offering cells
    write_reg(CFG_GRID_COLUMNS, 16'd1);
    write_reg(CFG_GRID_ROWS, 16'd40);
    set_idling(NO_IDLE);
    stall_request <= ~stall_request;
    repeat (40) push_cell(pick_value(FILL_TIES, '0), 1'b0, NONE);

    random_cells = 0;
    set_idling(SEND_LIGHT_TAKE_HEAVY);
    while (random_cells < RANDOM_CELLS) begin
      if (random_cells >= 2 * RANDOM_CELLS / 3)
        set_idling(NO_IDLE);
      else if (random_cells >= RANDOM_CELLS / 3)
        set_idling(SEND_HEAVY_TAKE_LIGHT);
      pick = $urandom_range(99);
      new_cols = (pick < 6) ? 0 : (pick < 16) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      pick = $urandom_range(99);
      new_rows = (pick < 6) ? 0 : (pick < 12) ? 16'hFFFF : $urandom_range(1, 6);
      case ($urandom_range(5))
        0: write_reg(CFG_GRID_COLUMNS, {5'($urandom), 11'(new_cols)});
        1: write_reg(CFG_GRID_ROWS, 16'(new_rows));
        2: begin
          write_reg(CFG_GRID_ROWS, 16'(new_rows));
          write_reg(CFG_GRID_COLUMNS, {5'($urandom), 11'(new_cols)});
        end
        default: begin
          write_reg(CFG_GRID_COLUMNS, {5'($urandom), 11'(new_cols)});
          write_reg(CFG_GRID_ROWS, 16'(new_rows));
        end
      endcase
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
      per_grid = active_cols() * active_rows();
      grids = (per_grid > 60) ? 1 : $urandom_range(1, 3);
      for (int g = 0; g < grids; g++) begin
        sent = per_grid;
        if (active_rows() > 64)
          sent = $urandom_range(1, 3 * active_cols());
        else if (g == grids - 1 && per_grid > 1 && $urandom_range(99) < 15)
          sent = $urandom_range(1, per_grid - 1);
        style = fill_style_t'($urandom_range(3));
        base = {$urandom, $urandom};
        repeat (sent) begin
          push_cell(pick_value(style, base), 1'b0, NONE);
          random_cells++;
        end
      end
    end

    settle();
    $display("Run covered %0d cells and %0d register writes; %0d row reports checked.",
             cells_sent, writes_done, reports_seen);
    $display("Grids ran from 1x1 to 40 columns with a %0d-cycle receiver hold; %0d mismatches.",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0)
      $display("grid_local_peak_counter_unit_tb OK");
    else
      $display("grid_local_peak_counter_unit_tb NOT OK");
    $finish;
  end

endmodule
